>>> src/serial_command_line_framer_core_macros.svh
// assertion macros shared by the framer checker
`ifndef SERIAL_COMMAND_LINE_FRAMER_CORE_MACROS_SVH
`define SERIAL_COMMAND_LINE_FRAMER_CORE_MACROS_SVH

// same-cycle implication
`define SCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("framer check failed");

// next-cycle implication
`define SCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("framer check failed");

`endif

>>> src/scf_pkg.sv
// shared types, codes and constants of the command line framer
`timescale 1ns / 1ps
`default_nettype none
package scf_pkg;

	localparam int LINE_DEPTH_DEF = 32;
	localparam int LINE_DEPTH_MAX = 65;
	// enough bits for any character count up to LINE_DEPTH_MAX - 1
	localparam int LEN_W = $clog2(LINE_DEPTH_MAX);

	localparam logic [7:0] START_RESET = 8'd36;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] PRINT_LO    = 8'h20;
	localparam logic [7:0] PRINT_HI    = 8'h7E;

	// input functions
	localparam logic [1:0] FUNC_BYTE      = 2'd0;
	localparam logic [1:0] FUNC_FRAME_ERR = 2'd1;
	localparam logic [1:0] FUNC_FETCH     = 2'd2;
	localparam logic [1:0] FUNC_TAKE_ERR  = 2'd3;

	// reply kinds
	localparam logic [1:0] KIND_CHAR   = 2'd0;
	localparam logic [1:0] KIND_NONE   = 2'd1;
	localparam logic [1:0] KIND_REPORT = 2'd2;

	// error flag bits
	localparam logic [2:0] FLAG_FRAME = 3'b001;
	localparam logic [2:0] FLAG_BUSY  = 3'b010;
	localparam logic [2:0] FLAG_LONG  = 3'b100;

	// back-end operations
	localparam logic [1:0] OP_NONE   = 2'd0;
	localparam logic [1:0] OP_REPORT = 2'd1;
	localparam logic [1:0] OP_CHARS  = 2'd2;

	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic [1:0]       op;
		logic [LEN_W-1:0] len;
		logic [2:0]       errs;
	} scf_cmd_t;

endpackage
`default_nettype wire

>>> src/scf_ifs.sv
// valid/ready channel interfaces for items and replies
`timescale 1ns / 1ps
`default_nettype none
interface scf_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;
	logic [7:0] dest_size;

	modport source (output valid, func, data_byte, dest_size, input ready);
	modport sink (input valid, func, data_byte, dest_size, output ready);
endinterface

interface scf_reply_if;
	logic       valid;
	logic       ready;
	logic [1:0] reply_kind;
	logic [6:0] char_value;
	logic       char_valid;
	logic       last;
	logic [2:0] error_bits;

	modport source (output valid, reply_kind, char_value, char_valid, last, error_bits,
		input ready);
	modport sink (input valid, reply_kind, char_value, char_valid, last, error_bits,
		output ready);
endinterface
`default_nettype wire

>>> src/scf_front.sv
// front end: takes items, runs the line framer and queues reader commands
`timescale 1ns / 1ps
`default_nettype none
module scf_front #(
	parameter int LINE_DEPTH = scf_pkg::LINE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	scf_item_if.sink                      item,
	input  logic                          cfg_we,
	input  logic [7:0]                    cfg_wdata,
	input  logic                          q_full,
	input  logic                          rd_busy,
	output logic                          push,
	output scf_pkg::scf_cmd_t             cmd,
	output logic                          wr_en,
	output logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
	output logic [6:0]                    wr_data
);
	import scf_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);
	localparam logic [AW-1:0] FILL_MAX = AW'(LINE_DEPTH - 1);

	localparam logic [1:0] M_WAIT    = 2'd0;
	localparam logic [1:0] M_RECEIVE = 2'd1;
	localparam logic [1:0] M_DISCARD = 2'd2;

	logic [1:0]    mode_q, mode_d;
	logic [AW-1:0] fill_q, fill_d;
	logic [AW-1:0] held_q, held_d;
	logic          cmd_held_q, cmd_held_d;
	logic [2:0]    flags_q, flags_d;
	logic [7:0]    start_char_q;

	logic       fire;
	logic       is_start, is_eol, is_print;
	logic [7:0] held8, size_m1, fetch_n;

	always_comb begin
		case (item.func)
			FUNC_BYTE:      item.ready = !rd_busy;
			FUNC_FRAME_ERR: item.ready = 1'b1;
			default:        item.ready = !q_full;
		endcase
	end

	assign fire     = item.valid && item.ready;
	assign is_start = item.data_byte == start_char_q;
	assign is_eol   = item.data_byte == CHAR_CR || item.data_byte == CHAR_LF;
	assign is_print = item.data_byte >= PRINT_LO && item.data_byte <= PRINT_HI;

	assign held8   = 8'(held_q);
	assign size_m1 = item.dest_size - 8'd1;
	assign fetch_n = (held8 < size_m1) ? held8 : size_m1;

	assign wr_addr = fill_q;
	assign wr_data = item.data_byte[6:0];

	always_comb begin
		mode_d     = mode_q;
		fill_d     = fill_q;
		held_d     = held_q;
		cmd_held_d = cmd_held_q;
		flags_d    = flags_q;
		wr_en      = 1'b0;
		push       = 1'b0;
		cmd        = '0;
		if (fire) begin
			unique case (item.func)
				FUNC_BYTE: begin
					if (cmd_held_q) begin
						if (is_start) flags_d = flags_q | FLAG_BUSY;
					end else begin
						unique case (mode_q)
							M_WAIT: begin
								if (is_start) begin
									fill_d = '0;
									mode_d = M_RECEIVE;
								end
							end
							M_RECEIVE: begin
								if (is_start) begin
									fill_d = '0;
								end else if (is_eol) begin
									if (fill_q != '0) begin
										held_d     = fill_q;
										cmd_held_d = 1'b1;
									end
									fill_d = '0;
									mode_d = M_WAIT;
								end else if (is_print) begin
									if (fill_q < FILL_MAX) begin
										wr_en  = 1'b1;
										fill_d = fill_q + AW'(1);
									end else begin
										flags_d = flags_q | FLAG_LONG;
										fill_d  = '0;
										mode_d  = M_DISCARD;
									end
								end else begin
									fill_d = '0;
									mode_d = M_DISCARD;
								end
							end
							default: begin
								// discard, and the unused code
								if (is_start) begin
									fill_d = '0;
									mode_d = M_RECEIVE;
								end else if (is_eol) begin
									fill_d = '0;
									mode_d = M_WAIT;
								end
							end
						endcase
					end
				end
				FUNC_FRAME_ERR: begin
					flags_d = flags_q | FLAG_FRAME;
					mode_d  = M_WAIT;
					fill_d  = '0;
				end
				FUNC_TAKE_ERR: begin
					push     = 1'b1;
					cmd.op   = OP_REPORT;
					cmd.errs = flags_q;
					flags_d  = '0;
				end
				default: begin
					push = 1'b1;
					if (item.dest_size == 8'd0 || !cmd_held_q) begin
						cmd.op = OP_NONE;
					end else begin
						cmd.op     = OP_CHARS;
						cmd.len    = fetch_n[LEN_W-1:0];
						cmd_held_d = 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_WAIT;
			fill_q       <= '0;
			held_q       <= '0;
			cmd_held_q   <= 1'b0;
			flags_q      <= '0;
			start_char_q <= START_RESET;
		end else begin
			mode_q     <= mode_d;
			fill_q     <= fill_d;
			held_q     <= held_d;
			cmd_held_q <= cmd_held_d;
			flags_q    <= flags_d;
			if (cfg_we) start_char_q <= cfg_wdata;
		end
	end

endmodule
`default_nettype wire

>>> src/scf_queue.sv
// short command queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module scf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  scf_pkg::scf_cmd_t push_cmd,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output scf_pkg::scf_cmd_t head
);
	import scf_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	scf_cmd_t       slot_q [Q_DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full  = count_q == CW'(Q_DEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> src/scf_back.sv
// back end: line store and reply sequencer with output register
`timescale 1ns / 1ps
`default_nettype none
module scf_back #(
	parameter int LINE_DEPTH = scf_pkg::LINE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
	input  logic [6:0]                    wr_data,
	input  logic                          q_empty,
	input  scf_pkg::scf_cmd_t             head,
	output logic                          pop,
	output logic                          busy,
	scf_reply_if.source                   reply
);
	import scf_pkg::*;

	localparam int AW          = $clog2(LINE_DEPTH);
	localparam int STORE_DEPTH = LINE_DEPTH - 1;

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_STREAM = 1'b1;

	logic [6:0] store_mem [STORE_DEPTH];
	logic [6:0] rd_q;
	logic       rd_en;
	logic [AW-1:0] rd_addr;

	logic             state_q, state_d;
	logic [AW-1:0]    idx_q, idx_d;
	logic [LEN_W-1:0] len_q, len_d;

	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [6:0] char_q;
	logic       cval_q, last_q;
	logic [2:0] errs_q;

	logic       out_free, load, is_last;
	logic [1:0] kind_d;
	logic [6:0] char_d;
	logic       cval_d, last_d;
	logic [2:0] errs_d;

	always_ff @(posedge clk) begin
		if (wr_en) store_mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= store_mem[rd_addr];
	end

	assign out_free = !out_valid_q || reply.ready;
	assign is_last  = LEN_W'(idx_q) + LEN_W'(1) == len_q;
	assign busy     = state_q == S_STREAM;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		len_d   = len_q;
		pop     = 1'b0;
		rd_en   = 1'b0;
		rd_addr = idx_q + AW'(1);
		load    = 1'b0;
		kind_d  = KIND_CHAR;
		char_d  = '0;
		cval_d  = 1'b0;
		last_d  = 1'b1;
		errs_d  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty && out_free) begin
					pop = 1'b1;
					unique case (head.op)
						OP_CHARS: begin
							if (head.len != '0) begin
								rd_en   = 1'b1;
								rd_addr = '0;
								idx_d   = '0;
								len_d   = head.len;
								state_d = S_STREAM;
							end else begin
								load = 1'b1;
							end
						end
						OP_REPORT: begin
							load   = 1'b1;
							kind_d = KIND_REPORT;
							errs_d = head.errs;
						end
						default: begin
							load   = 1'b1;
							kind_d = KIND_NONE;
						end
					endcase
				end
			end
			default: begin
				if (out_free) begin
					load   = 1'b1;
					char_d = rd_q;
					cval_d = 1'b1;
					last_d = is_last;
					if (is_last) begin
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q + AW'(1);
						rd_en = 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) out_valid_q <= 1'b1;
			else if (reply.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		len_q <= len_d;
		if (load) begin
			kind_q <= kind_d;
			char_q <= char_d;
			cval_q <= cval_d;
			last_q <= last_d;
			errs_q <= errs_d;
		end
	end

	assign reply.valid      = out_valid_q;
	assign reply.reply_kind = kind_q;
	assign reply.char_value = char_q;
	assign reply.char_valid = cval_q;
	assign reply.last       = last_q;
	assign reply.error_bits = errs_q;

endmodule
`default_nettype wire

>>> src/serial_command_line_framer_core.sv
// top level of the serial command line framer
// Frames received serial bytes into command lines opened by start_char (reset '$') and closed
// by CR or LF, holds one finished line, and hands it out on a fetch one character per reply
// transaction. Each item transaction carries one function: a received byte, a uart frame
// error, a fetch with the reader's buffer size, or a take-errors request. Bytes and frame
// errors produce no reply. Bytes are taken one per cycle while the store is not being read,
// and frame errors one per cycle at any time. Fetches and take-errors requests are taken one
// per cycle into a two-entry command queue while it has room. A take-errors request or an
// empty fetch is presented from the output register once the back end pops it. A fetch of n
// characters gives n replies at one per cycle while the reply side is ready, each character
// read through the line store's registered read port into the output register; received
// bytes are held off until the command queue is empty and that stream has drained.
`timescale 1ns / 1ps
`default_nettype none
module serial_command_line_framer_core #(
	parameter int LINE_DEPTH = scf_pkg::LINE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	scf_item_if.sink    item,
	scf_reply_if.source reply,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);
	import scf_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);

	// front to queue
	logic     push;
	scf_cmd_t push_cmd;

	// queue to back
	logic     q_full, q_empty, pop;
	scf_cmd_t head;

	// line store write port, owned by the front end
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [6:0]    wr_data;

	// back end streaming, or commands still waiting that may read the store
	logic back_busy;
	logic rd_busy;

	assign rd_busy = back_busy || !q_empty;

	scf_front #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_full   (q_full),
		.rd_busy  (rd_busy),
		.push     (push),
		.cmd      (push_cmd),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	scf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.head    (head)
	);

	scf_back #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.q_empty(q_empty),
		.head   (head),
		.pop    (pop),
		.busy   (back_busy),
		.reply  (reply)
	);

endmodule
`default_nettype wire

>>> src/scf_checker.sv
// port-level checker for the framer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "serial_command_line_framer_core_macros.svh"
module scf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       reply_valid,
	input logic       reply_ready,
	input logic [1:0] reply_kind,
	input logic [6:0] char_value,
	input logic       char_valid,
	input logic       last,
	input logic [2:0] error_bits
);
	import scf_pkg::*;

	// a stalled reply keeps its payload
	`SCF_ASSERT_NEXT(a_reply_hold, clk, arst_n, reply_valid && !reply_ready, reply_valid && $stable(reply_kind) && $stable(char_value) && $stable(char_valid) && $stable(last) && $stable(error_bits))

	// flags only travel on error reports
	`SCF_ASSERT_NOW(a_errs_on_report, clk, arst_n, reply_valid && reply_kind != KIND_REPORT, error_bits == 3'd0)

	// copied characters only on character replies
	`SCF_ASSERT_NOW(a_char_kind, clk, arst_n, reply_valid && char_valid, reply_kind == KIND_CHAR)

	// reports and empty answers are single replies
	`SCF_ASSERT_NOW(a_single_last, clk, arst_n, reply_valid && reply_kind != KIND_CHAR, last && !char_valid)

endmodule

bind serial_command_line_framer_core scf_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.reply_valid(reply.valid),
	.reply_ready(reply.ready),
	.reply_kind (reply.reply_kind),
	.char_value (reply.char_value),
	.char_valid (reply.char_valid),
	.last       (reply.last),
	.error_bits (reply.error_bits)
);
`default_nettype wire

>>> tb/sv/serial_command_line_framer_core_tb.sv
// self-checking testbench for the serial command line framer core
`timescale 1ns / 1ps
module serial_command_line_framer_core_tb;
	import scf_pkg::*;

	localparam int DEPTH        = LINE_DEPTH_DEF;
	localparam int MAX_WAIT     = 18;
	// cycles allowed for the block to go quiet once the last reply is in
	localparam int SETTLE       = 16;
	// cycles with no transaction at all before the run is declared hung
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 120;
	localparam int PHASES       = 6;

	typedef enum logic [1:0] {
		FR_WAIT    = 2'd0,
		FR_RECEIVE = 2'd1,
		FR_DISCARD = 2'd2
	} framer_mode_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] char_val;
		logic       char_ok;
		logic       last;
		logic [2:0] errs;
	} framer_reply_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	scf_item_if  item_ch ();
	scf_reply_if reply_ch ();

	serial_command_line_framer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.reply     (reply_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// framer state as the testbench sees it
	logic [7:0]    fr_start;
	framer_mode_t  fr_mode;
	logic [6:0]    fr_line [DEPTH];
	int            fr_fill;
	int            fr_held_len;
	logic          fr_held;
	logic [2:0]    fr_flags;

	// replies still owed by the block, oldest first
	framer_reply_t due_replies [$];

	int mismatch_count;
	int items_sent;
	bit no_gaps;
	int reply_stall;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// gap before an item or a reply; sometimes none at all
	function automatic int draw_wait();
		if (no_gaps || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// printable byte that cannot be taken for the start character
	function automatic logic [7:0] random_printable();
		logic [7:0] v;
		do begin
			v = 8'($urandom_range(PRINT_LO, PRINT_HI));
		end while (v == fr_start);
		return v;
	endfunction

	function automatic logic [7:0] random_eol();
		return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
	endfunction

	task automatic owe_reply(input logic [1:0] kind, input logic [6:0] ch, input logic ok,
		input logic last, input logic [2:0] errs);
		framer_reply_t r;
		r.kind     = kind;
		r.char_val = ch;
		r.char_ok  = ok;
		r.last     = last;
		r.errs     = errs;
		due_replies.push_back(r);
	endtask

	// advance the framer state by one accepted item and queue what it owes
	task automatic frame_and_reply(input logic [1:0] func, input logic [7:0] b,
		input logic [7:0] size);
		logic is_start;
		logic is_eol;
		int   n;
		is_start = (b == fr_start);
		is_eol   = (b == CHAR_CR) || (b == CHAR_LF);
		case (func)
			FUNC_BYTE: begin
				if (fr_held) begin
					// a held command blocks the line; only a start is noticed
					if (is_start)
						fr_flags |= FLAG_BUSY;
				end else begin
					case (fr_mode)
						FR_WAIT: begin
							if (is_start) begin
								fr_fill = 0;
								fr_mode = FR_RECEIVE;
							end
						end
						FR_RECEIVE: begin
							if (is_start) begin
								fr_fill = 0;
							end else if (is_eol) begin
								if (fr_fill > 0) begin
									fr_held_len = fr_fill;
									fr_held     = 1'b1;
								end
								fr_fill = 0;
								fr_mode = FR_WAIT;
							end else if (b >= PRINT_LO && b <= PRINT_HI) begin
								if (fr_fill + 1 < DEPTH) begin
									fr_line[fr_fill] = b[6:0];
									fr_fill++;
								end else begin
									fr_flags |= FLAG_LONG;
									fr_fill = 0;
									fr_mode = FR_DISCARD;
								end
							end else begin
								fr_fill = 0;
								fr_mode = FR_DISCARD;
							end
						end
						default: begin
							// discard, and the unused code behaves the same
							if (is_start) begin
								fr_fill = 0;
								fr_mode = FR_RECEIVE;
							end else if (is_eol) begin
								fr_fill = 0;
								fr_mode = FR_WAIT;
							end
						end
					endcase
				end
			end
			FUNC_FRAME_ERR: begin
				fr_flags |= FLAG_FRAME;
				fr_mode = FR_WAIT;
				fr_fill = 0;
			end
			FUNC_TAKE_ERR: begin
				owe_reply(KIND_REPORT, 7'd0, 1'b0, 1'b1, fr_flags);
				fr_flags = '0;
			end
			default: begin
				if (size == 8'd0 || !fr_held) begin
					owe_reply(KIND_NONE, 7'd0, 1'b0, 1'b1, 3'd0);
				end else begin
					n = fr_held_len;
					if (n > int'(size) - 1)
						n = int'(size) - 1;
					if (n > DEPTH - 1)
						n = DEPTH - 1;
					fr_held = 1'b0;
					if (n == 0)
						owe_reply(KIND_CHAR, 7'd0, 1'b0, 1'b1, 3'd0);
					for (int i = 0; i < n; i++)
						owe_reply(KIND_CHAR, fr_line[i], 1'b1, i == n - 1, 3'd0);
				end
			end
		endcase
	endtask

	// one item transaction: random gap, then hold valid until ready
	task automatic send_item(input logic [1:0] func, input logic [7:0] data,
		input logic [7:0] size);
		int gap;
		gap = draw_wait();
		repeat (gap) begin
			@(negedge clk);
			item_ch.valid = 1'b0;
		end
		@(negedge clk);
		item_ch.valid     = 1'b1;
		item_ch.func      = func;
		item_ch.data_byte = data;
		item_ch.dest_size = size;
		do begin
			@(posedge clk);
		end while (item_ch.ready !== 1'b1);
		frame_and_reply(func, data, size);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		send_item(FUNC_BYTE, b, junk);
	endtask

	task automatic send_fetch(input logic [7:0] size);
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		send_item(FUNC_FETCH, junk, size);
	endtask

	task automatic send_take();
		logic [7:0] junk;
		logic [7:0] junk2;
		junk  = 8'($urandom_range(0, 255));
		junk2 = 8'($urandom_range(0, 255));
		send_item(FUNC_TAKE_ERR, junk, junk2);
	endtask

	task automatic send_frame_err();
		logic [7:0] junk;
		logic [7:0] junk2;
		junk  = 8'($urandom_range(0, 255));
		junk2 = 8'($urandom_range(0, 255));
		send_item(FUNC_FRAME_ERR, junk, junk2);
	endtask

	// start, len printable characters, then the given terminator
	task automatic send_line(input int len, input logic [7:0] term);
		send_byte(fr_start);
		repeat (len) send_byte(random_printable());
		send_byte(term);
	endtask

	// drop valid and wait until the block owes nothing and has gone quiet
	task automatic settle();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (due_replies.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_start_char(input logic [7:0] v);
		settle();
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we   = 1'b0;
		fr_start = v;
	endtask

	task automatic check_field(input string what, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	// reply side: ready paced per transaction, every accepted reply checked
	initial begin : reply_pacing
		reply_ch.ready = 1'b0;
		reply_stall    = 0;
		forever begin
			@(negedge clk);
			if (reply_stall > 0) begin
				reply_ch.ready = 1'b0;
				reply_stall--;
			end else begin
				reply_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : reply_check
		framer_reply_t want;
		if (arst_n && reply_ch.valid === 1'b1 && reply_ch.ready === 1'b1) begin
			if (due_replies.size() == 0) begin
				$display("%0t: reply with none owed, expected nothing actual %h %h %b %b %b",
					$time, reply_ch.reply_kind, reply_ch.char_value, reply_ch.char_valid,
					reply_ch.last, reply_ch.error_bits);
				mismatch_count++;
			end else begin
				want = due_replies.pop_front();
				check_field("reply_kind", 8'(want.kind), 8'(reply_ch.reply_kind));
				check_field("char_value", 8'(want.char_val), 8'(reply_ch.char_value));
				check_field("char_valid", 8'(want.char_ok), 8'(reply_ch.char_valid));
				check_field("last", 8'(want.last), 8'(reply_ch.last));
				check_field("error_bits", 8'(want.errs), 8'(reply_ch.error_bits));
			end
			reply_stall = draw_wait();
		end
	end

	// hang detection: any transaction, register write or reset restarts the count
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
				(reply_ch.valid === 1'b1 && reply_ch.ready === 1'b1) ||
				cfg_we || !arst_n)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no transaction for %0d cycles, %0d replies outstanding", $time,
			STALL_LIMIT, due_replies.size());
		$display("status: fail");
		$finish;
	end

	// flags clear and nothing held straight out of reset
	task automatic test_after_reset();
		no_gaps = 1'b1;
		send_take();
		send_fetch(8'd255);
		send_fetch(8'd0);
		no_gaps = 1'b0;
	endtask

	// each framing rule once, with the reset start character
	task automatic test_framing_cases();
		// printable extremes, closed by lf
		send_byte(fr_start);
		send_byte(PRINT_LO);
		send_byte(PRINT_HI);
		send_byte(CHAR_LF);
		// while held a start only raises busy, anything else is dropped
		send_byte(fr_start);
		send_byte(8'hFF);
		// zero size keeps the command, size two hands out one character
		send_fetch(8'd0);
		send_fetch(8'd2);
		// empty line holds nothing
		send_byte(fr_start);
		send_byte(CHAR_CR);
		// a second start restarts the line; size one frees it with no character
		send_byte(fr_start);
		send_byte("Q");
		send_byte(fr_start);
		send_byte("R");
		send_byte(CHAR_CR);
		send_fetch(8'd1);
		// frame error part-way empties the line and waits for a start
		send_byte(fr_start);
		send_byte("K");
		send_frame_err();
		send_byte("M");
		// stray control byte sends the line to discard, which ignores printables
		send_byte(fr_start);
		send_byte(8'h7F);
		send_byte("P");
		send_byte(fr_start);
		send_byte("S");
		send_byte(CHAR_LF);
		// frame error leaves a held command alone
		send_frame_err();
		send_take();
		send_fetch(8'd255);
	endtask

	// longest line that fits, one that overflows, and a fetch cut short by size
	task automatic test_line_limits();
		send_line(DEPTH - 1, CHAR_CR);
		send_fetch(8'd255);
		send_line(DEPTH, CHAR_LF);
		send_take();
		send_fetch(8'd255);
		send_line(DEPTH - 1, CHAR_LF);
		send_fetch(8'd10);
	endtask

	// mostly whole lines with random content, with broken lines and noise mixed in
	task automatic random_traffic(input int quota);
		int         stop_at;
		int         pick;
		int         len;
		logic [7:0] b;
		logic [7:0] sz;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			pick    = $urandom_range(0, 15);
			if (pick < 9) begin
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(DEPTH - 3, DEPTH + 1);
				else
					len = $urandom_range(0, 8);
				send_line(len, random_eol());
				if ($urandom_range(0, 3) == 0)
					send_take();
				case ($urandom_range(0, 3))
					0: sz = 8'($urandom_range(0, 255));
					1: sz = 8'd255;
					default: sz = 8'($urandom_range(0, 12));
				endcase
				send_fetch(sz);
			end else if (pick < 12) begin
				// line broken by a restart, a frame error or a control byte
				send_byte(fr_start);
				repeat ($urandom_range(0, 4)) send_byte(random_printable());
				case ($urandom_range(0, 2))
					0: send_byte(fr_start);
					1: send_frame_err();
					default: begin
						if ($urandom_range(0, 1))
							b = 8'($urandom_range(0, 31));
						else
							b = 8'($urandom_range(127, 255));
						send_byte(b);
					end
				endcase
				repeat ($urandom_range(0, 3)) send_byte(random_printable());
				if ($urandom_range(0, 1))
					send_byte(random_eol());
			end else if (pick < 14) begin
				// any function with any payload
				repeat ($urandom_range(1, 4)) begin
					b  = 8'($urandom_range(0, 255));
					sz = 8'($urandom_range(0, 255));
					send_item(2'($urandom_range(0, 3)), b, sz);
				end
			end else if (pick == 14) begin
				send_take();
			end else begin
				// sender holds off until every reply is back
				settle();
			end
		end
		no_gaps = 1'b0;
	endtask

	// random traffic under several start characters, extremes included
	task automatic test_start_settings();
		logic [7:0] starts [PHASES];
		starts    = '{START_RESET, 8'h00, 8'hFF, CHAR_CR, 8'h41, 8'h00};
		starts[5] = 8'($urandom_range(0, 255));
		foreach (starts[k]) begin
			set_start_char(starts[k]);
			random_traffic(RANDOM_ITEMS / PHASES);
		end
	endtask

	initial begin : stimulus
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = 8'd0;
		item_ch.valid     = 1'b0;
		item_ch.func      = FUNC_BYTE;
		item_ch.data_byte = 8'd0;
		item_ch.dest_size = 8'd0;
		fr_start          = START_RESET;
		fr_mode           = FR_WAIT;
		fr_fill           = 0;
		fr_held_len       = 0;
		fr_held           = 1'b0;
		fr_flags          = '0;
		mismatch_count    = 0;
		items_sent        = 0;
		no_gaps           = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_after_reset();
		test_framing_cases();
		test_line_limits();
		test_start_settings();

		settle();
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/scf_pkg.sv
src/scf_ifs.sv
src/scf_front.sv
src/scf_queue.sv
src/scf_back.sv
src/serial_command_line_framer_core.sv
src/scf_checker.sv
tb/sv/serial_command_line_framer_core_tb.sv
